[sv/nsrgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsrgb_pkg
// Shared widths, register indexes and divider constants for the
// nearest-neighbour scaler and rgbx to bgr24 converter.
// ----------------------------------------------------------------------------
package nsrgb_pkg;

  // configuration register widths
  localparam int CFG_SIZE_W  = 13;
  localparam int CFG_PITCH_W = 15;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_PITCH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RB    = 3'd5;

  // payload widths
  localparam int PIXEL_W = 32;
  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 26;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEPS = 2;

endpackage

[sv/nearest_scale_rgbx_to_bgr24.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_scale_rgbx_to_bgr24
// Destination-ordered nearest-neighbour scaler: turns each fetched rgbx
// source pixel into a bgr24 word with its destination offset, and works out
// the source offset to fetch for the next destination position.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | in_valid_i / in_stall_o  | pixel_word_i
//  output   | out_valid_o / out_stall_i| blue_o green_o red_o target_offset_o
//           |                          | next_source_offset_o row_done_o
//           |                          | frame_done_o
//  config   | cfg_we_i                 | cfg_index_i cfg_data_i
//
//  An accepted word runs through the states MUL_T, MUL_X, DIV_X, MUL_Y,
//  DIV_Y, MUL_S and DONE before it loads the output register, and the input
//  stays stalled until the sequencer is back in IDLE. The time is set by the
//  shared radix-4 restoring divider, run once for the column and once for
//  the row, and the shared multiplier used four times per word.
//  Reset clears the counters and the sequencer and returns the config
//  registers to their defaults.
//  A waiting result sits in the output register; a stalled output holds the
//  sequencer in its last state until the register frees.
// ----------------------------------------------------------------------------
module nearest_scale_rgbx_to_bgr24
  import nsrgb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_W-1:0]    pixel_word_i,
  // output words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     blue_o,
  output logic [BYTE_W-1:0]     green_o,
  output logic [BYTE_W-1:0]     red_o,
  output logic [OFF_W-1:0]      target_offset_o,
  output logic [OFF_W-1:0]      next_source_offset_o,
  output logic                  row_done_o,
  output logic                  frame_done_o
);

  // derived widths
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int TWW  = $clog2(MAX_WIDTH + 1);
  localparam int THW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = (TWW > THW) ? TWW : THW;
  localparam int EXW  = (XW > CFG_SIZE_W) ? XW : CFG_SIZE_W;
  localparam int SW_W = XW + 2;
  localparam int MB_W = (SW_W > CFG_PITCH_W) ? SW_W : CFG_PITCH_W;
  localparam int PW   = OFF_W + MB_W;
  localparam int DW   = ((CW > RW) ? CW : RW) + CFG_SIZE_W;
  localparam int NI   = (DW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DWP  = NI * DIV_STEPS;
  localparam int NW   = (NI > 1) ? $clog2(NI) : 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_T = 3'd1;
  localparam logic [2:0] S_MUL_X = 3'd2;
  localparam logic [2:0] S_DIV_X = 3'd3;
  localparam logic [2:0] S_MUL_Y = 3'd4;
  localparam logic [2:0] S_DIV_Y = 3'd5;
  localparam logic [2:0] S_MUL_S = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // configuration registers
  logic [CFG_SIZE_W-1:0]  src_width_q, src_height_q, tgt_width_q, tgt_height_q;
  logic [CFG_PITCH_W-1:0] src_pitch_q;
  logic                   swap_rb_q;

  // sequencer and counters
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] col_q, cur_col_q;
  logic [RW-1:0] row_q, cur_row_q;
  logic          row_end_q, frame_end_q;
  logic [NW-1:0] cnt_q;

  // datapath registers
  logic [BYTE_W-1:0] px_blue_q, px_green_q, px_red_q;
  logic [PW-1:0]     prod_q;
  logic [OFF_W-1:0]  toff_q, sx_q;
  logic [XW:0]       rem_q;
  logic [DWP-1:0]    quo_q;

  // output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_blue_q, out_green_q, out_red_q;
  logic [OFF_W-1:0]  out_toff_q, out_nso_q;
  logic              out_row_q, out_frame_q;

  logic            in_acc, out_free;
  logic [XW-1:0]   tw, th, tw_m1, th_m1, div_v;
  logic [SW_W-1:0] stride;
  logic            row_end, frame_end;
  logic [OFF_W-1:0] mul_a, col3, nso;
  logic [MB_W-1:0]  mul_b;
  logic [PW-1:0]    mul_p;
  logic [XW:0]      rem_v;
  logic [DWP-1:0]   quo_v;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // clamp target sizes to 1..max
  always_comb begin
    if (tgt_width_q == '0) begin
      tw = XW'(1);
    end else if (EXW'(tgt_width_q) > EXW'(MAX_WIDTH)) begin
      tw = XW'(MAX_WIDTH);
    end else begin
      tw = XW'(tgt_width_q);
    end
    if (tgt_height_q == '0) begin
      th = XW'(1);
    end else if (EXW'(tgt_height_q) > EXW'(MAX_HEIGHT)) begin
      th = XW'(MAX_HEIGHT);
    end else begin
      th = XW'(tgt_height_q);
    end
  end

  assign tw_m1 = tw - XW'(1);
  assign th_m1 = th - XW'(1);

  // destination row stride padded to 4 bytes
  assign stride = (SW_W'(tw) + (SW_W'(tw) << 1) + SW_W'(3)) & ~SW_W'(3);

  // end of row and frame for the current position
  assign row_end   = XW'(col_q) >= tw_m1;
  assign frame_end = row_end && (XW'(row_q) >= th_m1);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL_T: begin
        mul_a = OFF_W'(cur_row_q);
        mul_b = MB_W'(stride);
      end
      S_MUL_X: begin
        mul_a = OFF_W'(col_q);
        mul_b = MB_W'(src_width_q);
      end
      S_MUL_Y: begin
        mul_a = OFF_W'(row_q);
        mul_b = MB_W'(src_height_q);
      end
      S_MUL_S: begin
        mul_a = OFF_W'(quo_q);
        mul_b = MB_W'(src_pitch_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // shared divider, two quotient bits per cycle
  assign div_v = (state_q == S_DIV_Y) ? th : tw;

  always_comb begin
    rem_v = rem_q;
    quo_v = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_v = {rem_v[XW-1:0], quo_v[DWP-1]};
      quo_v = {quo_v[DWP-2:0], 1'b0};
      if (rem_v >= {1'b0, div_v}) begin
        rem_v    = rem_v - {1'b0, div_v};
        quo_v[0] = 1'b1;
      end
    end
  end

  assign col3 = OFF_W'(cur_col_q) + (OFF_W'(cur_col_q) << 1);
  assign nso  = OFF_W'(prod_q) + (sx_q << 2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MUL_T;
      S_MUL_T: state_d = S_MUL_X;
      S_MUL_X: state_d = S_DIV_X;
      S_DIV_X: if (cnt_q == NW'(NI - 1)) state_d = S_MUL_Y;
      S_MUL_Y: state_d = S_DIV_Y;
      S_DIV_Y: if (cnt_q == NW'(NI - 1)) state_d = S_MUL_S;
      S_MUL_S: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= CFG_SIZE_W'(1);
      src_height_q <= CFG_SIZE_W'(1);
      tgt_width_q  <= CFG_SIZE_W'(1);
      tgt_height_q <= CFG_SIZE_W'(1);
      src_pitch_q  <= CFG_PITCH_W'(4);
      swap_rb_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_TGT_WIDTH:  tgt_width_q  <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_TGT_HEIGHT: tgt_height_q <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_SRC_PITCH:  src_pitch_q  <= cfg_data_i[CFG_PITCH_W-1:0];
        REG_SWAP_RB:    swap_rb_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (row_end) begin
          col_q <= '0;
          row_q <= frame_end ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (state_q == S_DIV_X || state_q == S_DIV_Y) begin
        cnt_q <= (cnt_q == NW'(NI - 1)) ? '0 : cnt_q + NW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_col_q   <= col_q;
      cur_row_q   <= row_q;
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
      px_green_q  <= pixel_word_i[2*BYTE_W-1:BYTE_W];
      px_blue_q   <= swap_rb_q ? pixel_word_i[3*BYTE_W-1:2*BYTE_W]
                               : pixel_word_i[BYTE_W-1:0];
      px_red_q    <= swap_rb_q ? pixel_word_i[BYTE_W-1:0]
                               : pixel_word_i[3*BYTE_W-1:2*BYTE_W];
    end
    unique case (state_q)
      S_MUL_T: prod_q <= mul_p;
      S_MUL_X: begin
        toff_q <= OFF_W'(prod_q) + col3;
        quo_q  <= DWP'(mul_p);
        rem_q  <= '0;
      end
      S_DIV_X, S_DIV_Y: begin
        quo_q <= quo_v;
        rem_q <= rem_v;
      end
      S_MUL_Y: begin
        sx_q  <= OFF_W'(quo_q);
        quo_q <= DWP'(mul_p);
        rem_q <= '0;
      end
      S_MUL_S: prod_q <= mul_p;
      default: ;
    endcase
    if (state_q == S_DONE && out_free) begin
      out_blue_q  <= px_blue_q;
      out_green_q <= px_green_q;
      out_red_q   <= px_red_q;
      out_toff_q  <= toff_q;
      out_nso_q   <= nso;
      out_row_q   <= row_end_q;
      out_frame_q <= frame_end_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign blue_o               = out_blue_q;
  assign green_o              = out_green_q;
  assign red_o                = out_red_q;
  assign target_offset_o      = out_toff_q;
  assign next_source_offset_o = out_nso_q;
  assign row_done_o           = out_row_q;
  assign frame_done_o         = out_frame_q;

`ifndef SYNTHESIS
  // an accepted word blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not blocked after accept");

  // frame end only on a row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_done_o || row_done_o))
    else $error("frame end without row end");

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_X || state_q == S_DIV_Y) |-> (rem_q < {1'b0, div_v}))
    else $error("divider remainder out of range");

  // column counter stays inside the clamped row after an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_T) |-> (XW'(col_q) <= tw_m1))
    else $error("column counter past row end");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-neighbour scaler and bgr24 converter.
// A short stimulus table covers byte swapping, target sizes of zero and above
// the maximum, odd source sizes and pitches, and counters left past the end
// of a smaller frame. Random frame setups with random pixels follow. Every
// accepted output word is checked against a local prediction of the
// destination bytes, offsets and end flags.
// ----------------------------------------------------------------------------
module tb;
  import nsrgb_pkg::*;

  localparam int TGT_MAX_W    = 4096;
  localparam int TGT_MAX_H    = 4096;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1150;
  localparam int QUIET_ITEMS  = 150;
  localparam int HOLD_PHASE   = 2;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [OFF_W-1:0]  target_offset;
    logic [OFF_W-1:0]  next_source_offset;
    logic              row_done;
    logic              frame_done;
  } bgr_word_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] src_w;
    logic [CFG_DATA_W-1:0] src_h;
    logic [CFG_DATA_W-1:0] tgt_w;
    logic [CFG_DATA_W-1:0] tgt_h;
    logic [CFG_DATA_W-1:0] pitch;
    logic                  swap;
  } scale_cfg_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    scale_cfg_t         cfg;
    logic [PIXEL_W-1:0] pixel;
    logic               typed;
    bgr_word_t          want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PIXEL_W-1:0]    pixel_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [BYTE_W-1:0]     blue_o;
  logic [BYTE_W-1:0]     green_o;
  logic [BYTE_W-1:0]     red_o;
  logic [OFF_W-1:0]      target_offset_o;
  logic [OFF_W-1:0]      next_source_offset_o;
  logic                  row_done_o;
  logic                  frame_done_o;

  // tag that travels with the offered word
  logic      offer_typed = 1'b0;
  bgr_word_t offer_want = '0;

  bit        gaps_on = 1'b1;
  bit        stalls_on = 1'b1;
  bit        hold_req = 1'b0;
  int        idle_cycles = 0;
  int        mismatch_count = 0;
  int        word_count = 0;
  bgr_word_t pending_words[$];
  stim_row_t stim_table[$];

  // shadow of the frame setup and destination counters
  logic [12:0]           sw_q = 13'd1;
  logic [12:0]           sh_q = 13'd1;
  logic [12:0]           tw_q = 13'd1;
  logic [12:0]           th_q = 13'd1;
  logic [CFG_PITCH_W-1:0] pitch_q = 15'd4;
  logic                  swap_q = 1'b0;
  logic [11:0]           col_q = '0;
  logic [11:0]           row_q = '0;

  nearest_scale_rgbx_to_bgr24 #(
    .MAX_WIDTH (TGT_MAX_W),
    .MAX_HEIGHT(TGT_MAX_H)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .pixel_word_i        (pixel_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .blue_o              (blue_o),
    .green_o             (green_o),
    .red_o               (red_o),
    .target_offset_o     (target_offset_o),
    .next_source_offset_o(next_source_offset_o),
    .row_done_o          (row_done_o),
    .frame_done_o        (frame_done_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // zero acts as one, oversize acts as the maximum
  function automatic longint unsigned clamp_target(logic [12:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return 64'(lim);
    return 64'(v);
  endfunction

  // destination bytes and offsets for one fetched pixel, then advance counters
  task automatic scale_step(input logic [PIXEL_W-1:0] px, output bgr_word_t res);
    longint unsigned tw, th, stride, col, row, toff, sx, sy, soff;
    bit row_end, frame_end;
    tw = clamp_target(tw_q, TGT_MAX_W);
    th = clamp_target(th_q, TGT_MAX_H);
    stride = ((tw * 3 + 3) / 4) * 4;
    col = 64'(col_q);
    row = 64'(row_q);
    toff = row * stride + col * 3;
    row_end = (col >= tw - 1);
    frame_end = row_end && (row >= th - 1);
    if (row_end) begin
      col = 0;
      row = frame_end ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
    col_q = col[11:0];
    row_q = row[11:0];
    sx = (col * sw_q) / tw;
    sy = (row * sh_q) / th;
    soff = sy * pitch_q + sx * 4;
    res.blue = swap_q ? px[23:16] : px[7:0];
    res.green = px[15:8];
    res.red = swap_q ? px[7:0] : px[23:16];
    res.target_offset = toff[OFF_W-1:0];
    res.next_source_offset = soff[OFF_W-1:0];
    res.row_done = row_end;
    res.frame_done = frame_end;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH word %0d: %s", word_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // input and output word monitor
  always @(posedge clk_i) begin
    bgr_word_t want;
    bgr_word_t model;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_words.size() == 0) begin
          report_mismatch("output word with none pending");
        end else begin
          want = pending_words.pop_front();
          check_field("blue", 32'(blue_o), 32'(want.blue));
          check_field("green", 32'(green_o), 32'(want.green));
          check_field("red", 32'(red_o), 32'(want.red));
          check_field("target_offset", 32'(target_offset_o),
                      32'(want.target_offset));
          check_field("next_source_offset", 32'(next_source_offset_o),
                      32'(want.next_source_offset));
          check_field("row_done", 32'(row_done_o), 32'(want.row_done));
          check_field("frame_done", 32'(frame_done_o), 32'(want.frame_done));
        end
        word_count++;
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        scale_step(pixel_word_i, model);
        pending_words.push_back(offer_typed ? offer_want : model);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // offer one word and wait for it to be taken
  task automatic send_word(input logic [PIXEL_W-1:0] px, input logic typed,
                           input bgr_word_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_word_i <= px;
    offer_typed <= typed;
    offer_want <= want;
    @(posedge clk_i);
    while (!(in_valid_i && !in_stall_o)) @(posedge clk_i);
  endtask

  // stop offering and wait for every pending word
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH:  sw_q = val[12:0];
      REG_SRC_HEIGHT: sh_q = val[12:0];
      REG_TGT_WIDTH:  tw_q = val[12:0];
      REG_TGT_HEIGHT: th_q = val[12:0];
      REG_SRC_PITCH:  pitch_q = val[CFG_PITCH_W-1:0];
      REG_SWAP_RB:    swap_q = val[0];
      default: ;
    endcase
  endtask

  // full frame setup, sometimes with writes to unused indexes
  task automatic load_config(input scale_cfg_t c);
    put_reg(REG_SRC_WIDTH, c.src_w);
    put_reg(REG_SRC_HEIGHT, c.src_h);
    put_reg(REG_TGT_WIDTH, c.tgt_w);
    put_reg(REG_TGT_HEIGHT, c.tgt_h);
    put_reg(REG_SRC_PITCH, c.pitch);
    if ($urandom_range(0, 3) == 0) begin
      put_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 32767)));
      put_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 32767)));
    end
    put_reg(REG_SWAP_RB, {14'd0, c.swap});
    cfg_we_i <= 1'b0;
  endtask

  function automatic scale_cfg_t pick_config();
    scale_cfg_t c;
    c.src_w = CFG_DATA_W'($urandom_range(1, 4096));
    c.src_h = CFG_DATA_W'($urandom_range(1, 4096));
    c.tgt_w = CFG_DATA_W'($urandom_range(1, 8));
    c.tgt_h = CFG_DATA_W'($urandom_range(1, 6));
    c.pitch = CFG_DATA_W'($urandom_range(4, 16384));
    c.swap = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: begin
        c.src_w = 15'd4096;
        c.tgt_w = 15'd4096;
        c.tgt_h = CFG_DATA_W'($urandom_range(1, 3));
        c.pitch = 15'd16384;
      end
      1: begin
        c.src_w = CFG_DATA_W'($urandom_range(0, 32767));
        c.src_h = CFG_DATA_W'($urandom_range(0, 32767));
        c.tgt_w = CFG_DATA_W'($urandom_range(0, 32767));
        c.tgt_h = CFG_DATA_W'($urandom_range(0, 32767));
        c.pitch = CFG_DATA_W'($urandom_range(0, 32767));
      end
      2: begin
        c.src_w = 15'd8191;
        c.src_h = 15'd8191;
        c.tgt_w = 15'd0;
        c.tgt_h = CFG_DATA_W'($urandom_range(0, 2));
        c.pitch = 15'h7FFF;
      end
      3: begin
        c.tgt_w = 15'd1;
        c.tgt_h = 15'd1;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic stim_row_t cfg_row(input scale_cfg_t c);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg = c;
    return r;
  endfunction

  function automatic stim_row_t word_row(input logic [PIXEL_W-1:0] px,
                                         input logic typed, input bgr_word_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.pixel = px;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // stimulus
  initial begin
    int done_items;
    int phase;
    int n;
    done_items = 0;
    phase = 0;

    // after reset: 1x1 frames, every word ends row and frame at offset 0
    stim_table.push_back(word_row(32'hAABBCCDD, 1'b1,
                                  {8'hDD, 8'hCC, 8'hBB, 52'd0, 2'b11}));
    stim_table.push_back(word_row(32'hFFFFFFFF, 1'b1,
                                  {8'hFF, 8'hFF, 8'hFF, 52'd0, 2'b11}));
    stim_table.push_back(word_row(32'h00000000, 1'b1, {24'd0, 52'd0, 2'b11}));
    // red and blue swapped
    stim_table.push_back(cfg_row({15'd1, 15'd1, 15'd1, 15'd1, 15'd4, 1'b1}));
    stim_table.push_back(word_row(32'h11223344, 1'b1,
                                  {8'h22, 8'h33, 8'h44, 52'd0, 2'b11}));
    // zero target size acts as one
    stim_table.push_back(cfg_row({15'd3, 15'd3, 15'd0, 15'd0, 15'd12, 1'b0}));
    stim_table.push_back(word_row(32'h00FF00FF, 1'b1,
                                  {8'hFF, 8'h00, 8'hFF, 52'd0, 2'b11}));
    // small 3x2 frame, once round and one more
    stim_table.push_back(cfg_row({15'd5, 15'd4, 15'd3, 15'd2, 15'd20, 1'b0}));
    repeat (7) stim_table.push_back(word_row($urandom, 1'b0, '0));
    // oversized target clamps to the maximum
    stim_table.push_back(cfg_row({15'd4096, 15'd4096, 15'h1FFF, 15'h7FFF,
                                  15'd16384, 1'b1}));
    repeat (2) stim_table.push_back(word_row($urandom, 1'b0, '0));
    // zero source width and pitch, column past the new last column
    stim_table.push_back(cfg_row({15'd0, 15'd8191, 15'd2, 15'd3, 15'd0, 1'b0}));
    repeat (2) stim_table.push_back(word_row($urandom, 1'b0, '0));
    // oversized source and pitch, source offset wraps
    stim_table.push_back(cfg_row({15'd8191, 15'd8191, 15'd3, 15'd2, 15'h7FFF,
                                  1'b1}));
    repeat (3) stim_table.push_back(word_row($urandom, 1'b0, '0));
    // tall frame, then row past the new last row
    stim_table.push_back(cfg_row({15'd7, 15'd9, 15'd1, 15'd8, 15'd64, 1'b0}));
    repeat (4) stim_table.push_back(word_row($urandom, 1'b0, '0));
    stim_table.push_back(cfg_row({15'd7, 15'd9, 15'd1, 15'd2, 15'd64, 1'b0}));
    repeat (2) stim_table.push_back(word_row($urandom, 1'b0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        drain();
        load_config(stim_table[i].cfg);
      end else begin
        send_word(stim_table[i].pixel, stim_table[i].typed, stim_table[i].want);
      end
    end

    // random frame setups with random pixels
    while (done_items < RANDOM_ITEMS) begin
      drain();
      load_config(pick_config());
      n = $urandom_range(40, 120);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      for (int k = 0; k < n && done_items < RANDOM_ITEMS; k++) begin
        send_word($urandom, 1'b0, '0);
        done_items++;
        if (done_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
          gaps_on = 1'b0;
          stalls_on = 1'b0;
        end
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/nsrgb_pkg.sv
sv/nearest_scale_rgbx_to_bgr24.sv
tb/sv/tb.sv
